@@ rtl/afc_pkg.sv @@
// afc_pkg: widths, payload types and helpers for the box/frustum classifier
// depends on nothing; used by the interfaces, afc_cell and the top level
`default_nettype none

package afc_pkg;

    // block configuration
    localparam int NUM_PLANES = 6;
    localparam int COORD_BITS = 20;
    localparam int COEF_BITS  = 16;

    // plane register layout: a,b,c,d in 16-bit slots, a lowest
    localparam int PLANE_W   = 64;
    localparam int SLOT_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int AXES      = 3;
    localparam int SLOT_D    = 3;

    // arithmetic widths, all exact
    localparam int SUM_W  = COORD_BITS + 1;
    localparam int MAG_W  = COEF_BITS + 1;
    localparam int PROD_W = MAG_W + SUM_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int CMP_W  = ACC_W + 1;

    // front stage, three stages per cell, output register
    localparam int CELL_STAGES = 3;
    localparam int PIPE_DEPTH  = NUM_PLANES * CELL_STAGES + 2;
    localparam int OCC_W       = $clog2(PIPE_DEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef logic signed [MAG_W-1:0]      mag_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [ACC_W-1:0]      acc_t;
    typedef logic signed [CMP_W-1:0]      cmp_t;

    typedef enum logic [1:0] {
        VERDICT_INSIDE    = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_OUTSIDE   = 2'd2
    } verdict_t;

    // box as it moves down the chain, plus the running verdict flags
    typedef struct packed {
        logic [AXES-1:0][SUM_W-1:0] sum;
        logic [AXES-1:0][SUM_W-1:0] ext;
        logic                       all_in;
        logic                       any_out;
    } chain_t;

    // plane register write broadcast to every cell
    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] idx;
        logic [PLANE_W-1:0]   data;
    } cfg_wr_t;

    function automatic coef_t plane_coef(input logic [PLANE_W-1:0] plane,
                                         input int unsigned slot);
        return coef_t'(plane[SLOT_W*slot +: COEF_BITS]);
    endfunction

    function automatic mag_t coef_mag(input coef_t n);
        mag_t wide;
        wide = mag_t'(n);
        return (wide < 0) ? -wide : wide;
    endfunction

endpackage

`default_nettype wire

@@ rtl/afc_ifs.sv @@
// afc_ifs: valid/ready channel interfaces for boxes, verdicts and plane writes
// depends on afc_pkg
`default_nettype none

interface afc_box_if;
    logic                   valid;
    logic                   ready;
    afc_pkg::coord_t        min_x;
    afc_pkg::coord_t        min_y;
    afc_pkg::coord_t        min_z;
    afc_pkg::coord_t        max_x;
    afc_pkg::coord_t        max_y;
    afc_pkg::coord_t        max_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    output ready);
endinterface

interface afc_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

interface afc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [afc_pkg::CFG_IDX_W-1:0]   index;
    logic [afc_pkg::PLANE_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/afc_cell.sv @@
// afc_cell: one plane of the culling chain, holds its plane register and
// runs a three-stage test on each box passing through; depends on afc_pkg
`default_nettype none

module afc_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [afc_pkg::CFG_IDX_W-1:0] cell_idx,
    input  wire afc_pkg::cfg_wr_t              cfg_wr,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire afc_pkg::chain_t               up_data,
    output logic                               dn_valid,
    input  wire logic                          dn_ready,
    output afc_pkg::chain_t                    dn_data
);

    logic [afc_pkg::PLANE_W-1:0] plane_reg;

    afc_pkg::coef_t  n    [afc_pkg::AXES];
    afc_pkg::mag_t   m    [afc_pkg::AXES];
    afc_pkg::coef_t  n_d;

    // stage 1: products
    logic            v1_reg;
    afc_pkg::chain_t d1_reg;
    afc_pkg::prod_t  pn_reg   [afc_pkg::AXES];
    afc_pkg::prod_t  pm_reg   [afc_pkg::AXES];
    afc_pkg::prod_t  pn_next  [afc_pkg::AXES];
    afc_pkg::prod_t  pm_next  [afc_pkg::AXES];

    // stage 2: center and extent distances
    logic            v2_reg;
    afc_pkg::chain_t d2_reg;
    afc_pkg::acc_t   s2_reg;
    afc_pkg::acc_t   e2_reg;
    afc_pkg::acc_t   s2_next;
    afc_pkg::acc_t   e2_next;

    // stage 3: flag update
    logic            v3_reg;
    afc_pkg::chain_t d3_reg;
    afc_pkg::chain_t d3_next;
    afc_pkg::cmp_t   hi;
    afc_pkg::cmp_t   lo;
    logic            in_p;
    logic            out_p;

    logic free1, free2, free3;

    always_comb
    begin
        for (int i = 0; i < afc_pkg::AXES; i++)
        begin
            n[i] = afc_pkg::plane_coef(plane_reg, i);
            m[i] = afc_pkg::coef_mag(n[i]);
        end
        n_d = afc_pkg::plane_coef(plane_reg, afc_pkg::SLOT_D);
    end

    assign free3    = !v3_reg || dn_ready;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign up_ready = free1;

    always_comb
    begin
        for (int i = 0; i < afc_pkg::AXES; i++)
        begin
            pn_next[i] = afc_pkg::prod_t'(n[i])
                       * afc_pkg::prod_t'(afc_pkg::sum_t'(up_data.sum[i]));
            pm_next[i] = afc_pkg::prod_t'(m[i])
                       * afc_pkg::prod_t'(afc_pkg::sum_t'(up_data.ext[i]));
        end
    end

    always_comb
    begin
        s2_next = afc_pkg::acc_t'(pn_reg[0]) + afc_pkg::acc_t'(pn_reg[1])
                + afc_pkg::acc_t'(pn_reg[2]) + (afc_pkg::acc_t'(n_d) <<< 1);
        e2_next = afc_pkg::acc_t'(pm_reg[0]) + afc_pkg::acc_t'(pm_reg[1])
                + afc_pkg::acc_t'(pm_reg[2]);
    end

    // inner side wins over the outside test for the same plane
    always_comb
    begin
        hi    = afc_pkg::cmp_t'(s2_reg) - afc_pkg::cmp_t'(e2_reg);
        lo    = afc_pkg::cmp_t'(s2_reg) + afc_pkg::cmp_t'(e2_reg);
        in_p  = !hi[afc_pkg::CMP_W-1] && (hi != '0);
        out_p = !in_p && lo[afc_pkg::CMP_W-1];
        d3_next         = d2_reg;
        d3_next.all_in  = d2_reg.all_in && in_p;
        d3_next.any_out = d2_reg.any_out || out_p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr.en && (cfg_wr.idx == cell_idx))
            begin
                plane_reg <= cfg_wr.data;
            end
            if (free1)
            begin
                v1_reg <= up_valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free1 && up_valid)
        begin
            d1_reg <= up_data;
            pn_reg <= pn_next;
            pm_reg <= pm_next;
        end
        if (free2 && v1_reg)
        begin
            d2_reg <= d1_reg;
            s2_reg <= s2_next;
            e2_reg <= e2_next;
        end
        if (free3 && v2_reg)
        begin
            d3_reg <= d3_next;
        end
    end

    assign dn_valid = v3_reg;
    assign dn_data  = d3_reg;

endmodule

`default_nettype wire

@@ rtl/aabb_frustum_cull_unit.sv @@
// aabb_frustum_cull_unit: top level, box front stage, chain of plane cells,
// verdict output register; depends on afc_pkg, afc_ifs and afc_cell
`default_nettype none

//  channel  dir  handshake      payload
//  box      in   valid/ready    min_x min_y min_z max_x max_y max_z (20b signed)
//  result   out  valid/ready    verdict (0 inside, 1 intersecting, 2 outside)
//  cfg      in   valid/ready    index (plane 0..5), data (a,b,c,d packed, a lowest)
//
//  one box per cycle sustained while result is not stalled; stages: front stage, three stages
//  per plane cell (products, distance sums, compare), output register
//  reset clears all planes to zero and empties the pipeline
//  each stage moves when its successor is empty or moving, so bubbles close
//  up and new boxes are taken while a verdict waits; box.ready drops only
//  when every stage is full and result is stalled
//  cfg is always ready; writes to index 6 or 7 are dropped

module aabb_frustum_cull_unit (
    input  wire logic      clk,
    input  wire logic      rst_n,
    afc_box_if.sink        box,
    afc_verdict_if.source  result,
    afc_cfg_if.sink        cfg
);

    // chain links: link 0 is the front stage, link NUM_PLANES the last cell
    logic            link_v [afc_pkg::NUM_PLANES+1];
    logic            link_r [afc_pkg::NUM_PLANES+1];
    afc_pkg::chain_t link_d [afc_pkg::NUM_PLANES+1];

    afc_pkg::cfg_wr_t cfg_wr;

    // front stage: corner sum and extent per axis
    logic            v0_reg;
    afc_pkg::chain_t d0_reg;
    afc_pkg::chain_t d0_next;
    logic            free0;

    // output register
    logic              vo_reg;
    afc_pkg::verdict_t verdict_reg;
    afc_pkg::verdict_t verdict_next;
    logic              freeo;

    // items in flight, for checking
    logic [afc_pkg::OCC_W-1:0] occ_reg;
    logic [afc_pkg::OCC_W-1:0] occ_next;
    logic                      box_xfer;
    logic                      res_xfer;

    assign cfg.ready  = 1'b1;
    assign cfg_wr.en   = cfg.valid;
    assign cfg_wr.idx  = cfg.index;
    assign cfg_wr.data = cfg.data;

    assign free0     = !v0_reg || link_r[0];
    assign box.ready = free0;
    assign box_xfer  = box.valid && free0;

    always_comb
    begin
        d0_next.sum[0] = afc_pkg::sum_t'(box.min_x) + afc_pkg::sum_t'(box.max_x);
        d0_next.sum[1] = afc_pkg::sum_t'(box.min_y) + afc_pkg::sum_t'(box.max_y);
        d0_next.sum[2] = afc_pkg::sum_t'(box.min_z) + afc_pkg::sum_t'(box.max_z);
        // inverted corners give a negative extent, kept as is
        d0_next.ext[0] = afc_pkg::sum_t'(box.max_x) - afc_pkg::sum_t'(box.min_x);
        d0_next.ext[1] = afc_pkg::sum_t'(box.max_y) - afc_pkg::sum_t'(box.min_y);
        d0_next.ext[2] = afc_pkg::sum_t'(box.max_z) - afc_pkg::sum_t'(box.min_z);
        d0_next.all_in  = 1'b1;
        d0_next.any_out = 1'b0;
    end

    assign link_v[0] = v0_reg;
    assign link_d[0] = d0_reg;

    for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++)
    begin : g_cell
        afc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (afc_pkg::CFG_IDX_W'(p)),
            .cfg_wr   (cfg_wr),
            .up_valid (link_v[p]),
            .up_ready (link_r[p]),
            .up_data  (link_d[p]),
            .dn_valid (link_v[p+1]),
            .dn_ready (link_r[p+1]),
            .dn_data  (link_d[p+1])
        );
    end

    assign freeo                       = !vo_reg || result.ready;
    assign link_r[afc_pkg::NUM_PLANES] = freeo;
    assign res_xfer                    = vo_reg && result.ready;

    // outside on any plane has priority over inside on all planes
    always_comb
    begin
        priority if (link_d[afc_pkg::NUM_PLANES].any_out)
        begin
            verdict_next = afc_pkg::VERDICT_OUTSIDE;
        end
        else if (link_d[afc_pkg::NUM_PLANES].all_in)
        begin
            verdict_next = afc_pkg::VERDICT_INSIDE;
        end
        else
        begin
            verdict_next = afc_pkg::VERDICT_INTERSECT;
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (box_xfer && !res_xfer)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (res_xfer && !box_xfer)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            vo_reg  <= 1'b0;
            occ_reg <= '0;
        end
        else
        begin
            if (free0)
            begin
                v0_reg <= box.valid;
            end
            if (freeo)
            begin
                vo_reg <= link_v[afc_pkg::NUM_PLANES];
            end
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (box_xfer)
        begin
            d0_reg <= d0_next;
        end
        if (freeo && link_v[afc_pkg::NUM_PLANES])
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign result.valid   = vo_reg;
    assign result.verdict = verdict_reg;

    // pipeline never holds more boxes than it has stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= afc_pkg::OCC_W'(afc_pkg::PIPE_DEPTH))
        else $error("more boxes in flight than pipeline stages");

    // a verdict is only offered for a box that was taken
    a_res_has_box: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (occ_reg != '0))
        else $error("verdict offered with no box in flight");

    // input back-pressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !box.ready |-> (result.valid && !result.ready))
        else $error("box channel stalled without result stall");

    // a full pipeline with a stalled result holds every stage
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_reg == afc_pkg::OCC_W'(afc_pkg::PIPE_DEPTH)) && !result.ready)
        |-> !box.ready)
        else $error("box taken with full pipeline");

endmodule

`default_nettype wire
